// ----- hw/rtl/http_chunked_body_splitter_core_assert.svh -----
// Assertion macros shared by the chunked body splitter RTL.
// Each macro expands to one labeled concurrent assertion on a clock and an active-low reset.
`ifndef HTTP_CHUNKED_BODY_SPLITTER_CORE_ASSERT_SVH
`define HTTP_CHUNKED_BODY_SPLITTER_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HCBS_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("hcbs assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define HCBS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("hcbs assertion failed");

`endif

// ----- hw/rtl/hcbs_pkg.sv -----
// Types and constants for the chunked body splitter.
// No dependencies; used by the front, queue, back and top modules.
package hcbs_pkg;

    localparam int BlockSizeWidth = 17;
    localparam logic [BlockSizeWidth-1:0] BlockSizeReset = 17'd16384;
    localparam int ChunkWidth = 32;
    localparam logic [3:0] MaxDigits = 4'd8;

    localparam logic [7:0] ChCr   = 8'h0d;
    localparam logic [7:0] ChLf   = 8'h0a;
    localparam logic [7:0] ChSemi = 8'h3b;
    localparam logic [7:0] ChZero = 8'h30;

    typedef logic [1:0] t_verdict;
    localparam t_verdict VerdictCont  = 2'd0;
    localparam t_verdict VerdictSlice = 2'd1;
    localparam t_verdict VerdictEnd   = 2'd2;
    localparam t_verdict VerdictAbort = 2'd3;

    typedef struct packed {
        logic       is_cr;
        logic       is_lf;
        logic       is_semi;
        logic       is_zero;
        logic       is_hex;
        logic [3:0] hex_val;
    } t_class;

endpackage

// ----- hw/rtl/hcbs_front.sv -----
// Front stage of the chunked body splitter: accepts bytes and classifies them.
// Depends on hcbs_pkg; feeds hcbs_queue.
module hcbs_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  logic [7:0]      i_data_byte,
    output logic            o_cls_valid,
    input  logic            i_cls_ready,
    output hcbs_pkg::t_class o_cls
);
    import hcbs_pkg::*;

    logic   r_valid;
    logic   n_valid;
    t_class r_cls;
    t_class n_cls;
    logic   w_accept;
    logic   w_digit;
    logic   w_alpha;

    assign o_in_ready  = !r_valid || i_cls_ready;
    assign w_accept    = i_in_valid && o_in_ready;
    assign o_cls_valid = r_valid;
    assign o_cls       = r_cls;

    always_comb begin
        w_digit = (i_data_byte >= 8'h30) && (i_data_byte <= 8'h39);
        w_alpha = ((i_data_byte >= 8'h41) && (i_data_byte <= 8'h46))
               || ((i_data_byte >= 8'h61) && (i_data_byte <= 8'h66));
        n_cls.is_cr   = (i_data_byte == ChCr);
        n_cls.is_lf   = (i_data_byte == ChLf);
        n_cls.is_semi = (i_data_byte == ChSemi);
        n_cls.is_zero = (i_data_byte == ChZero);
        n_cls.is_hex  = w_digit || w_alpha;
        n_cls.hex_val = w_digit ? i_data_byte[3:0] : (i_data_byte[3:0] + 4'd9);
        if (w_accept) begin
            n_valid = 1'b1;
        end else if (i_cls_ready) begin
            n_valid = 1'b0;
        end else begin
            n_valid = r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cls <= n_cls;
        end
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

endmodule

// ----- hw/rtl/hcbs_queue.sv -----
// Short queue of classified bytes between the front and back stages.
// Depends on hcbs_pkg and the assertion macro header.
`include "http_chunked_body_splitter_core_assert.svh"
module hcbs_queue #(
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push_valid,
    output logic             o_push_ready,
    input  hcbs_pkg::t_class i_push_data,
    output logic             o_pop_valid,
    input  logic             i_pop_ready,
    output hcbs_pkg::t_class o_pop_data
);
    import hcbs_pkg::*;

    localparam int PtrW = $clog2(DEPTH);
    localparam int CntW = $clog2(DEPTH + 1);

    t_class            r_mem [DEPTH];
    logic [PtrW-1:0]   r_wr_ptr;
    logic [PtrW-1:0]   r_rd_ptr;
    logic [CntW-1:0]   r_count;
    logic [PtrW-1:0]   n_wr_ptr;
    logic [PtrW-1:0]   n_rd_ptr;
    logic [CntW-1:0]   n_count;
    logic              w_push;
    logic              w_pop;

    assign o_push_ready = (r_count != CntW'(DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_data   = r_mem[r_rd_ptr];
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = o_pop_valid && i_pop_ready;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == PtrW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == PtrW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (w_push && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (w_pop && !w_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    `HCBS_ASSERT_NEXT(a_push_grows, i_clk, i_rst_n, w_push && !w_pop, r_count == $past(r_count) + 1'b1)
    `HCBS_ASSERT_NEXT(a_pop_shrinks, i_clk, i_rst_n, w_pop && !w_push, r_count == $past(r_count) - 1'b1)

endmodule

// ----- hw/rtl/hcbs_back.sv -----
// Back stage of the chunked body splitter: parser state machine and verdict register.
// Depends on hcbs_pkg and the assertion macro header; fed by hcbs_queue.
`include "http_chunked_body_splitter_core_assert.svh"
module hcbs_back (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [hcbs_pkg::BlockSizeWidth-1:0] i_cfg_wdata,
    input  logic                                i_cls_valid,
    output logic                                o_cls_ready,
    input  hcbs_pkg::t_class                    i_cls,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output hcbs_pkg::t_verdict                  o_verdict
);
    import hcbs_pkg::*;

    typedef enum logic [2:0] {
        PH_ZEROS,
        PH_NUMBER,
        PH_OPTIONS,
        PH_HCRLF,
        PH_DATA,
        PH_DCRLF1,
        PH_DCRLF2
    } t_phase;

    t_phase                    r_phase;
    t_phase                    n_phase;
    logic                      r_zero_seen;
    logic                      n_zero_seen;
    logic [ChunkWidth-1:0]     r_chunk;
    logic [ChunkWidth-1:0]     n_chunk;
    logic [3:0]                r_digits;
    logic [3:0]                n_digits;
    logic [BlockSizeWidth-1:0] r_slice;
    logic [BlockSizeWidth-1:0] n_slice;
    logic [BlockSizeWidth-1:0] r_block_size;
    logic                      r_out_valid;
    logic                      n_out_valid;
    t_verdict                  r_verdict;
    t_verdict                  n_verdict;
    logic                      w_pop;
    logic [BlockSizeWidth-1:0] w_slice_inc;
    logic                      w_end;
    logic                      w_stop;
    logic                      w_idle;

    assign o_cls_ready = !r_out_valid || i_out_ready;
    assign w_pop       = i_cls_valid && o_cls_ready;
    assign o_out_valid = r_out_valid;
    assign o_verdict   = r_verdict;
    assign w_slice_inc = r_slice + 1'b1;
    assign w_end       = w_pop && (n_verdict == VerdictEnd);
    assign w_stop      = w_pop && ((n_verdict == VerdictEnd) || (n_verdict == VerdictAbort));
    assign w_idle      = (r_phase == PH_ZEROS) && (r_slice == '0) && (r_chunk == '0);

    always_comb begin
        n_phase     = r_phase;
        n_zero_seen = r_zero_seen;
        n_chunk     = r_chunk;
        n_digits    = r_digits;
        n_slice     = r_slice;
        n_verdict   = r_verdict;
        n_out_valid = i_out_ready ? 1'b0 : r_out_valid;
        if (w_pop) begin
            n_out_valid = 1'b1;
            n_verdict   = VerdictCont;
            unique case (r_phase) inside
                PH_ZEROS, PH_NUMBER: begin
                    if ((r_phase == PH_ZEROS) && i_cls.is_zero) begin
                        n_zero_seen = 1'b1;
                    end else if (i_cls.is_cr) begin
                        n_phase = PH_HCRLF;
                    end else if (i_cls.is_semi) begin
                        n_phase = PH_OPTIONS;
                    end else if (!i_cls.is_hex || (r_digits == MaxDigits)) begin
                        n_verdict = VerdictAbort;
                    end else begin
                        n_phase  = PH_NUMBER;
                        n_digits = r_digits + 1'b1;
                        n_chunk  = {r_chunk[ChunkWidth-5:0], i_cls.hex_val};
                    end
                end
                PH_OPTIONS: begin
                    if (i_cls.is_cr) begin
                        n_phase = PH_HCRLF;
                    end else if (i_cls.is_lf) begin
                        n_verdict = VerdictAbort;
                    end
                end
                PH_HCRLF: begin
                    if (!i_cls.is_lf) begin
                        n_verdict = VerdictAbort;
                    end else if (r_chunk != '0) begin
                        n_phase = PH_DATA;
                    end else if (r_zero_seen) begin
                        n_verdict = VerdictEnd;
                    end else begin
                        n_verdict = VerdictAbort;
                    end
                end
                PH_DATA: begin
                    n_chunk = r_chunk - 1'b1;
                    if (r_chunk == ChunkWidth'(1)) begin
                        n_phase = PH_DCRLF1;
                    end
                    if (w_slice_inc >= r_block_size) begin
                        n_slice   = '0;
                        n_verdict = VerdictSlice;
                    end else begin
                        n_slice = w_slice_inc;
                    end
                end
                PH_DCRLF1: begin
                    if (!i_cls.is_cr) begin
                        n_verdict = VerdictAbort;
                    end else begin
                        n_phase = PH_DCRLF2;
                    end
                end
                PH_DCRLF2: begin
                    if (!i_cls.is_lf) begin
                        n_verdict = VerdictAbort;
                    end else begin
                        n_phase     = PH_ZEROS;
                        n_zero_seen = 1'b0;
                        n_chunk     = '0;
                        n_digits    = '0;
                    end
                end
                default: begin
                    n_verdict = VerdictAbort;
                end
            endcase
            if ((n_verdict == VerdictEnd) || (n_verdict == VerdictAbort)) begin
                n_phase     = PH_ZEROS;
                n_zero_seen = 1'b0;
                n_chunk     = '0;
                n_digits    = '0;
                n_slice     = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_verdict <= n_verdict;
        if (!i_rst_n) begin
            r_phase      <= PH_ZEROS;
            r_zero_seen  <= 1'b0;
            r_chunk      <= '0;
            r_digits     <= '0;
            r_slice      <= '0;
            r_block_size <= BlockSizeReset;
            r_out_valid  <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_zero_seen <= n_zero_seen;
            r_chunk     <= n_chunk;
            r_digits    <= n_digits;
            r_slice     <= n_slice;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_block_size <= i_cfg_wdata;
            end
        end
    end

    `HCBS_ASSERT_SAME(a_data_has_bytes, i_clk, i_rst_n, r_phase == PH_DATA, r_chunk != '0)
    `HCBS_ASSERT_SAME(a_end_needs_zero, i_clk, i_rst_n, w_end, (r_phase == PH_HCRLF) && r_zero_seen)
    `HCBS_ASSERT_NEXT(a_stop_clears, i_clk, i_rst_n, w_stop, w_idle)

endmodule

// ----- hw/rtl/http_chunked_body_splitter_core.sv -----
// Chunked body splitter: one verdict per body byte. A byte passes the front register,
// the queue and the verdict register; while the output is ready, throughput is one
// byte per cycle. The rate is set by the parser update in the back stage; the queue
// between front and back absorbs short output stalls, and a longer stall holds the input.
// Reset is synchronous and active low; it returns the parser to its start state
// and sets block_size to 16384.
module http_chunked_body_splitter_core #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [hcbs_pkg::BlockSizeWidth-1:0] i_cfg_wdata,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [7:0]                          i_data_byte,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [1:0]                          o_verdict
);
    import hcbs_pkg::*;

    t_class   w_front_cls;
    logic     w_front_valid;
    logic     w_front_ready;
    t_class   w_back_cls;
    logic     w_back_valid;
    logic     w_back_ready;
    t_verdict w_verdict;

    assign o_verdict = w_verdict;

    hcbs_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_data_byte (i_data_byte),
        .o_cls_valid (w_front_valid),
        .i_cls_ready (w_front_ready),
        .o_cls       (w_front_cls)
    );

    hcbs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_front_valid),
        .o_push_ready (w_front_ready),
        .i_push_data  (w_front_cls),
        .o_pop_valid  (w_back_valid),
        .i_pop_ready  (w_back_ready),
        .o_pop_data   (w_back_cls)
    );

    hcbs_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cls_valid (w_back_valid),
        .o_cls_ready (w_back_ready),
        .i_cls       (w_back_cls),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_verdict   (w_verdict)
    );

endmodule
